// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
// Used by sacl_ctrl, sacl_dp and set_assoc_cache_lru_sim; no dependencies.
package sacl_pkg;

   localparam int MAX_SETS = 64;
   localparam int MAX_WAYS = 8;
   localparam int SET_W    = $clog2(MAX_SETS);
   localparam int WAY_W    = $clog2(MAX_WAYS);
   localparam int NWAY_W   = WAY_W + 1;
   localparam int MASK_W   = (SET_W > 8) ? SET_W : 8;
   localparam int TAG_W    = 64;
   localparam int STAMP_W  = 32;
   localparam int CNT_W    = 32;

   // access kinds
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_STORE  = 2'd1;
   localparam logic [1:0] CMD_MODIFY = 2'd2;
   localparam logic [1:0] CMD_FETCH  = 2'd3;

   // result kinds
   localparam logic [1:0] OUT_HIT     = 2'd0;
   localparam logic [1:0] OUT_FILL    = 2'd1;
   localparam logic [1:0] OUT_EVICT   = 2'd2;
   localparam logic [1:0] OUT_IGNORED = 2'd3;

   // register indexes
   localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
   localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS        = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0] index_bits;
      logic [5:0] offset_bits;
      logic [3:0] ways;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } way_line_type;

   typedef struct packed {
      way_line_type [MAX_WAYS-1:0] line;
      logic [STAMP_W-1:0]          set_clock;
   } set_row_type;

   typedef struct packed {
      logic load;
      logic read;
      logic compare;
      logic update;
   } dp_cmd_type;

   typedef struct packed {
      logic fetch;
   } dp_status_type;

endpackage

// ===== rtl/sacl_ctrl.sv =====
// Controller of the cache model: walks each access through read, compare and update, skipping the compare for a fetch.
// Depends on sacl_pkg.
module sacl_ctrl import sacl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   ctrl_state_type state_ff, state_in;
   logic           strobe_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_READ;
         end
         ST_READ: begin
            // a fetch touches nothing: skip the compare
            state_in = status.fetch ? ST_UPDATE : ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.update;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/sacl_dp.sv =====
// Datapath of the cache model: set memory, tag compare, LRU victim tree and counters.
// Depends on sacl_pkg; sequenced by sacl_ctrl.
module sacl_dp import sacl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  cfg_type             cfg,
   input  logic [1:0]          req_cmd,
   input  logic [63:0]         req_address,
   output dp_status_type       status,
   output logic [1:0]          rsp_outcome,
   output logic                rsp_second_hit,
   output logic [CNT_W-1:0]    rsp_hit_count,
   output logic [CNT_W-1:0]    rsp_miss_count,
   output logic [CNT_W-1:0]    rsp_evict_count
);

   set_row_type mem [MAX_SETS];

   logic [MAX_SETS-1:0] row_valid_ff;
   set_row_type         row_rd_ff;
   logic                row_live_ff;
   set_row_type         row_cur;
   set_row_type         row_next;

   logic [TAG_W-1:0]  block_ff, block_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [MASK_W-1:0] set_mask;
   logic [1:0]        cmd_ff;
   logic [NWAY_W-1:0] nw_ff, nw_in;

   logic [MAX_WAYS-1:0] hit_vec_ff, hit_vec_in;
   logic [MAX_WAYS-1:0] inv_vec_ff, inv_vec_in;
   logic [STAMP_W-1:0]  age_ff [MAX_WAYS];
   logic [STAMP_W-1:0]  age_in [MAX_WAYS];

   logic [WAY_W-1:0]   hit_way, fill_way, victim_way, new_way;
   logic               hit, fill, is_fetch, is_modify;
   logic [STAMP_W-1:0] clock_next;
   logic [1:0]         outcome;

   logic [STAMP_W-1:0] tree_age [WAY_W+1][MAX_WAYS];
   logic [WAY_W-1:0]   tree_idx [WAY_W+1][MAX_WAYS];

   logic [1:0]       outcome_ff;
   logic             second_ff;
   logic [CNT_W-1:0] hits_ff, misses_ff, evicts_ff;
   logic [CNT_W-1:0] hits_in, misses_in, evicts_in;

   // address split and ways clamp at transfer time
   always_comb begin
      block_in = req_address >> cfg.offset_bits;
      set_mask = (MASK_W'(1) << cfg.index_bits) - MASK_W'(1);
      set_in   = block_in[SET_W-1:0] & set_mask[SET_W-1:0];
      if (cfg.ways == 4'd0)
         nw_in = NWAY_W'(1);
      else if (32'(cfg.ways) > MAX_WAYS)
         nw_in = NWAY_W'(MAX_WAYS);
      else
         nw_in = NWAY_W'(cfg.ways);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         block_ff <= block_in;
         set_ff   <= set_in;
         cmd_ff   <= req_cmd;
         nw_ff    <= nw_in;
      end
   end

   assign is_fetch     = (cmd_ff == CMD_FETCH);
   assign is_modify    = (cmd_ff == CMD_MODIFY);
   assign status.fetch = is_fetch;

   // set memory: one row per set, read data registered
   always_ff @(posedge clock) begin
      if (cmd.read) row_rd_ff <= mem[set_ff];
      if (cmd.update && !is_fetch) mem[set_ff] <= row_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.update && !is_fetch) begin
         row_valid_ff[set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) row_live_ff <= row_valid_ff[set_ff];
   end

   // a set never written reads as empty with its clock at zero
   assign row_cur = row_live_ff ? row_rd_ff : '0;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (NWAY_W'(w) < nw_ff) begin
            hit_vec_in[w] = row_cur.line[w].valid && (row_cur.line[w].tag == block_ff);
            inv_vec_in[w] = !row_cur.line[w].valid;
            age_in[w]     = row_cur.set_clock - row_cur.line[w].stamp;
         end else begin
            hit_vec_in[w] = 1'b0;
            inv_vec_in[w] = 1'b0;
            age_in[w]     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_vec_ff <= hit_vec_in;
         inv_vec_ff <= inv_vec_in;
         age_ff     <= age_in;
      end
   end

   // lowest matching way and lowest free way
   always_comb begin
      hit_way  = '0;
      fill_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec_ff[w]) hit_way = WAY_W'(w);
         if (inv_vec_ff[w]) fill_way = WAY_W'(w);
      end
   end

   // oldest way; take the upper half only when strictly older, so ties go low
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         tree_age[0][w] = age_ff[w];
         tree_idx[0][w] = WAY_W'(w);
      end
      for (int l = 1; l <= WAY_W; l++) begin
         for (int p = 0; p < MAX_WAYS; p++) begin
            tree_age[l][p] = '0;
            tree_idx[l][p] = '0;
         end
         for (int p = 0; p < (MAX_WAYS >> l); p++) begin
            if (tree_age[l-1][2*p+1] > tree_age[l-1][2*p]) begin
               tree_age[l][p] = tree_age[l-1][2*p+1];
               tree_idx[l][p] = tree_idx[l-1][2*p+1];
            end else begin
               tree_age[l][p] = tree_age[l-1][2*p];
               tree_idx[l][p] = tree_idx[l-1][2*p];
            end
         end
      end
      victim_way = tree_idx[WAY_W][0];
   end

   always_comb begin
      hit        = |hit_vec_ff;
      fill       = |inv_vec_ff;
      clock_next = row_cur.set_clock + STAMP_W'(1);
      if (hit) begin
         new_way = hit_way;
         outcome = OUT_HIT;
      end else if (fill) begin
         new_way = fill_way;
         outcome = OUT_FILL;
      end else begin
         new_way = victim_way;
         outcome = OUT_EVICT;
      end
      row_next                     = row_cur;
      row_next.set_clock           = clock_next;
      row_next.line[new_way].valid = 1'b1;
      row_next.line[new_way].tag   = block_ff;
      row_next.line[new_way].stamp = clock_next;

      hits_in   = hits_ff + CNT_W'(hit) + CNT_W'(is_modify);
      misses_in = misses_ff + CNT_W'(!hit);
      evicts_in = evicts_ff + CNT_W'(outcome == OUT_EVICT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (cmd.update && !is_fetch) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         outcome_ff <= is_fetch ? OUT_IGNORED : outcome;
         second_ff  <= is_modify;
      end
   end

   assign rsp_outcome     = outcome_ff;
   assign rsp_second_hit  = second_ff;
   assign rsp_hit_count   = hits_ff;
   assign rsp_miss_count  = misses_ff;
   assign rsp_evict_count = evicts_ff;

endmodule

// ===== rtl/set_assoc_cache_lru_sim.sv =====
// Top level of the set-associative LRU cache model: config registers and glue.
// Depends on sacl_pkg, sacl_ctrl and sacl_dp.
//
//   channel   handshake            payload
//   request   start / busy         req_cmd, req_address
//   response  rsp_strobe           rsp_outcome, rsp_second_hit, rsp_*_count
//   config    csr_we               csr_index, csr_wdata
//
// An access runs from transfer to result strobe through a read of the set row from the
// set memory, a tag compare that also forms the ages, the LRU victim tree with the row
// write-back and the result register; an instruction fetch skips the compare. busy is
// high from transfer until the strobe cycle, where a new access may already be taken.
// Synchronous reset empties every set through per-set valid bits, with no clearing pass.
// The receiver cannot stall: each result shows for one cycle only.
module set_assoc_cache_lru_sim import sacl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_cmd,
   input  logic [63:0]      req_address,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_outcome,
   output logic             rsp_second_hit,
   output logic [CNT_W-1:0] rsp_hit_count,
   output logic [CNT_W-1:0] rsp_miss_count,
   output logic [CNT_W-1:0] rsp_evict_count,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_wdata
);

   cfg_type       cfg_ff;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.index_bits  <= 3'd1;
         cfg_ff.offset_bits <= 6'd1;
         cfg_ff.ways        <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_INDEX_BITS:  cfg_ff.index_bits  <= csr_wdata[2:0];
            REG_OFFSET_BITS: cfg_ff.offset_bits <= csr_wdata;
            REG_WAYS:        cfg_ff.ways        <= csr_wdata[3:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   sacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (dp_status),
      .cmd        (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   sacl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .cfg             (cfg_ff),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .status          (dp_status),
      .rsp_outcome     (rsp_outcome),
      .rsp_second_hit  (rsp_second_hit),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .rsp_evict_count (rsp_evict_count)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result strobe outside the end of an access");

   a_fetch_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcome == OUT_IGNORED |->
         rsp_hit_count == $past(rsp_hit_count) && rsp_miss_count == $past(rsp_miss_count))
      else $error("ignored access changed a count");

   a_hit_no_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcome == OUT_HIT |->
         rsp_miss_count == $past(rsp_miss_count) && rsp_evict_count == $past(rsp_evict_count))
      else $error("hit changed the miss or eviction count");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for set_assoc_cache_lru_sim: directed and random trace
// accesses under several cache geometries, checked against an in-bench LRU predictor.
// Depends on sacl_pkg and the set_assoc_cache_lru_sim RTL.
`timescale 1ns / 1ps

module tb;
   import sacl_pkg::*;

   localparam logic [1:0] REG_SPARE   = 2'd3;   // no register behind this index
   localparam int         CYCLE_LIMIT = 500000;
   localparam int         SETTLE      = 8;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] addr;
   } trace_access_type;

   typedef struct packed {
      logic [1:0]       outcome;
      logic             second_hit;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] misses;
      logic [CNT_W-1:0] evicts;
   } access_report_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic [1:0]       req_cmd     = CMD_LOAD;
   logic [63:0]      req_address = 64'd0;
   logic             csr_we      = 1'b0;
   logic [1:0]       csr_index   = REG_INDEX_BITS;
   logic [5:0]       csr_wdata   = 6'd0;
   logic             busy;
   logic             rsp_strobe;
   logic [1:0]       rsp_outcome;
   logic             rsp_second_hit;
   logic [CNT_W-1:0] rsp_hit_count;
   logic [CNT_W-1:0] rsp_miss_count;
   logic [CNT_W-1:0] rsp_evict_count;

   set_assoc_cache_lru_sim uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .rsp_strobe      (rsp_strobe),
      .rsp_outcome     (rsp_outcome),
      .rsp_second_hit  (rsp_second_hit),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .rsp_evict_count (rsp_evict_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow registers and cache contents of the predictor
   logic [2:0]         cfg_index_bits  = 3'd1;
   logic [5:0]         cfg_offset_bits = 6'd1;
   logic [3:0]         cfg_ways        = 4'd1;
   bit                 way_valid [MAX_SETS][MAX_WAYS];
   bit [63:0]          way_block [MAX_SETS][MAX_WAYS];
   bit [STAMP_W-1:0]   way_stamp [MAX_SETS][MAX_WAYS];
   bit [STAMP_W-1:0]   set_tick  [MAX_SETS];
   bit [CNT_W-1:0]     hits_seen;
   bit [CNT_W-1:0]     misses_seen;
   bit [CNT_W-1:0]     evicts_seen;

   trace_access_type  trace_q[$];
   access_report_type pending_reports[$];
   logic [63:0]       block_pool[$];
   int                fault_count = 0;
   int                cycle_count = 0;
   int                gap_left    = 0;
   bit                drain_hold  = 1'b0;
   bit                no_gaps     = 1'b0;

   function automatic access_report_type cache_lookup(input trace_access_type acc);
      access_report_type rep;
      logic [63:0]    blk;
      logic [63:0]    sel;
      int             set_no;
      int             nw;
      int             w;
      int             victim;
      bit             found;
      logic [31:0]    oldest;
      logic [31:0]    age;
      rep.outcome    = OUT_IGNORED;
      rep.second_hit = 1'b0;
      if (acc.cmd != CMD_FETCH) begin
         blk    = acc.addr >> cfg_offset_bits;
         sel    = blk & ((64'd1 << cfg_index_bits) - 64'd1);
         set_no = int'(sel % MAX_SETS);
         nw     = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
         found  = 1'b0;
         victim = 0;
         for (w = 0; w < nw && !found; w++) begin
            if (way_valid[set_no][w] && way_block[set_no][w] == blk) begin
               found       = 1'b1;
               victim      = w;
               rep.outcome = OUT_HIT;
            end
         end
         for (w = 0; w < nw && !found; w++) begin
            if (!way_valid[set_no][w]) begin
               found       = 1'b1;
               victim      = w;
               rep.outcome = OUT_FILL;
            end
         end
         if (!found) begin
            // oldest line goes; strict compare keeps the lowest way on a tie
            oldest = 32'd0;
            for (w = 0; w < nw; w++) begin
               age = set_tick[set_no] - way_stamp[set_no][w];
               if (age > oldest) begin
                  oldest = age;
                  victim = w;
               end
            end
            rep.outcome = OUT_EVICT;
         end
         set_tick[set_no]          += 1;
         way_valid[set_no][victim] = 1'b1;
         way_block[set_no][victim] = blk;
         way_stamp[set_no][victim] = set_tick[set_no];
         if (rep.outcome == OUT_HIT) begin
            hits_seen += 1;
         end else begin
            misses_seen += 1;
            if (rep.outcome == OUT_EVICT) evicts_seen += 1;
         end
         if (acc.cmd == CMD_MODIFY) begin
            hits_seen      += 1;
            rep.second_hit = 1'b1;
         end
      end
      rep.hits   = hits_seen;
      rep.misses = misses_seen;
      rep.evicts = evicts_seen;
      return rep;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fault_count++;
      end
   endtask

   // sender: hold the transfer while busy, idle in random bursts between accesses
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_reports.push_back(cache_lookup(trace_q[0]));
            trace_q.delete(0);
            if (!no_gaps && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 13);
            if (!no_gaps && $urandom_range(0, 299) == 0) drain_hold = 1'b1;
         end
         if (drain_hold && pending_reports.size() == 0) drain_hold = 1'b0;
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (drain_hold || trace_q.size() == 0) begin
               start <= 1'b0;
            end else begin
               start       <= 1'b1;
               req_cmd     <= trace_q[0].cmd;
               req_address <= trace_q[0].addr;
            end
         end
      end
   end

   // receiver: every strobe must match the oldest predicted access report
   always @(posedge clock) begin
      access_report_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual outcome %0d",
                     $time, rsp_outcome);
            fault_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("outcome", 32'(want.outcome), 32'(rsp_outcome));
            check_field("second_hit", 32'(want.second_hit), 32'(rsp_second_hit));
            check_field("hit_count", want.hits, rsp_hit_count);
            check_field("miss_count", want.misses, rsp_miss_count);
            check_field("evict_count", want.evicts, rsp_evict_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d accesses and %0d results outstanding",
                  $time, trace_q.size(), pending_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_INDEX_BITS:  cfg_index_bits  = value[2:0];
         REG_OFFSET_BITS: cfg_offset_bits = value;
         REG_WAYS:        cfg_ways        = value[3:0];
         default: ;
      endcase
   endtask

   task automatic queue_access(input logic [1:0] cmd, input logic [63:0] addr);
      trace_access_type acc;
      acc.cmd  = cmd;
      acc.addr = addr;
      trace_q.push_back(acc);
   endtask

   // wait until every access is transferred and every result is back
   task automatic drain_all();
      do @(posedge clock);
      while (trace_q.size() != 0 || start || pending_reports.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic fill_block_pool(input int n);
      block_pool.delete();
      repeat (n) block_pool.push_back({$urandom, $urandom});
   endtask

   // mostly reuse pool blocks so sets fill and evict; some fully random noise
   task automatic run_random(input int n);
      int          counted;
      logic [1:0]  kind;
      logic [63:0] addr;
      logic [63:0] blk;
      counted = 0;
      while (counted < n) begin
         if ($urandom_range(0, 99) < 8) kind = CMD_FETCH;
         else kind = 2'($urandom_range(0, 2));
         if ($urandom_range(0, 99) < 15) begin
            addr = {$urandom, $urandom};
         end else begin
            blk  = block_pool[$urandom_range(0, block_pool.size() - 1)];
            addr = (blk << cfg_offset_bits)
                 | ({$urandom, $urandom} & ((64'd1 << cfg_offset_bits) - 64'd1));
         end
         queue_access(kind, addr);
         counted++;
      end
      drain_all();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: two sets, one way, two-byte blocks
      queue_access(CMD_LOAD,   64'h0);
      queue_access(CMD_LOAD,   64'h1);
      queue_access(CMD_STORE,  64'h0);
      queue_access(CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_access(CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_access(CMD_FETCH,  64'h0);
      queue_access(CMD_FETCH,  64'hFFFF_FFFF_FFFF_FFFF);
      queue_access(CMD_LOAD,   64'h4);
      queue_access(CMD_STORE,  64'h0);
      queue_access(CMD_MODIFY, 64'h8);
      queue_access(CMD_LOAD,   64'h8000_0000_0000_0000);
      queue_access(CMD_STORE,  64'h5555_5555_5555_5555);
      queue_access(CMD_LOAD,   64'hAAAA_AAAA_AAAA_AAAA);
      queue_access(CMD_LOAD,   64'h2);
      queue_access(CMD_FETCH,  64'h5555_5555_5555_5555);
      queue_access(CMD_MODIFY, 64'h2);
      drain_all();
      fill_block_pool(8);
      run_random(150);

      // single set with all ways, then shrink and regrow over the same blocks
      write_reg(REG_WAYS, 6'd8);
      write_reg(REG_INDEX_BITS, 6'd0);
      write_reg(REG_OFFSET_BITS, 6'd0);
      fill_block_pool($urandom_range(10, 14));
      run_random(220);
      write_reg(REG_WAYS, 6'h22);
      run_random(200);
      write_reg(REG_WAYS, 6'd8);
      run_random(150);

      // upper register bits beyond the field width are dropped
      write_reg(REG_INDEX_BITS, 6'h3A);
      write_reg(REG_OFFSET_BITS, 6'd4);
      write_reg(REG_WAYS, 6'd4);
      fill_block_pool($urandom_range(10, 24));
      run_random(220);

      // index wider than the set array, top offset, ways clamped to the maximum
      write_reg(REG_INDEX_BITS, 6'd7);
      write_reg(REG_OFFSET_BITS, 6'd63);
      write_reg(REG_WAYS, 6'd15);
      fill_block_pool(6);
      run_random(200);

      // ways of zero act as one; spare index must not disturb anything
      write_reg(REG_INDEX_BITS, 6'd6);
      write_reg(REG_OFFSET_BITS, 6'd32);
      write_reg(REG_WAYS, 6'd0);
      write_reg(REG_SPARE, 6'h3F);
      fill_block_pool($urandom_range(40, 90));
      run_random(220);

      write_reg(REG_INDEX_BITS, 6'd3);
      write_reg(REG_OFFSET_BITS, 6'd6);
      write_reg(REG_WAYS, 6'h35);
      fill_block_pool($urandom_range(20, 50));
      run_random(250);

      // back-to-back transfers only
      no_gaps = 1'b1;
      write_reg(REG_INDEX_BITS, 6'd4);
      write_reg(REG_OFFSET_BITS, 6'd10);
      write_reg(REG_WAYS, 6'd3);
      fill_block_pool($urandom_range(20, 60));
      run_random(250);

      if (pending_reports.size() != 0) fault_count++;
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
